@@ src/blr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package blr_pkg;

  // Field widths
  localparam int unsigned LEVEL_W = 6;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned ACT_W   = 2;

  // Divider operand widths: numerator up to 63*200+62, divisor up to 200
  localparam int unsigned NUM_W  = 14;
  localparam int unsigned DEN_W  = 8;
  localparam int unsigned QUOT_W = 7;
  localparam int unsigned CNT_W  = 3;

  localparam logic [PCT_W-1:0] STEP_PCT = 7'd10;
  localparam logic [PCT_W-1:0] FULL_PCT = 7'd100;
  localparam logic [NUM_W-1:0] PCT_ROUND = 14'd100;
  localparam logic [DEN_W-1:0] PCT_SCALE = 8'd200;
  localparam logic [LEVEL_W-1:0] SPLIT_LEVEL = 6'd10;

  typedef enum logic [ACT_W-1:0] {
    ACT_SET    = 2'd0,
    ACT_UP     = 2'd1,
    ACT_DOWN   = 2'd2,
    ACT_REPORT = 2'd3
  } action_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ src/blr_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller guarantees
// that the quotient fits in QUOT_W bits.
module blr_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire blr_pkg::div_req_t req,
  output blr_pkg::div_rsp_t     rsp
);
  import blr_pkg::*;

  logic [NUM_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [QUOT_W-1:0] quot_r, quot_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [NUM_W:0]    trial;
  logic              fits;

  always_comb begin
    trial = {{(NUM_W+1-DEN_W){1'b0}}, den_r} << cnt_r;
    fits  = {1'b0, rem_r} >= trial;
  end

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.num;
      den_nxt  = req.den;
      quot_nxt = '0;
      cnt_nxt  = CNT_W'(QUOT_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // subtract the shifted divisor where it fits
      if (fits) begin
        rem_nxt = rem_r - trial[NUM_W-1:0];
      end
      quot_nxt = {quot_r[QUOT_W-2:0], fits};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still busy");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r <= CNT_W'(QUOT_W - 1)))
    else $error("divider bit count out of range");
`endif

endmodule

`default_nettype wire

@@ src/backlight_level_ramp.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Backlight level ramp.
// Input channel (in_*): one command transaction - set percent, step up or
// down by 10 percent, or an external level report. Taken when in_valid is
// high and in_stall low; in_stall stays high while a command is in hand.
// Result channel (out_*): one transaction per level written on the way to
// the target (out_write_valid high, out_last on the final one), or a
// single transaction with out_write_valid low when nothing is written.
// Config channel (cfg_*): writes max_level; cfg_ready is always high.
// Write it only between commands.
// A ramp writes up to 63 levels, and the shared divider converts every
// written level to a percent.
// Reset (synchronous, rst_n low) clears max_level, the held level and
// percent, and empties the result register.
// A stall on the result side holds the result register; the sequencer
// waits in its emit state and no result is lost or repeated.
module backlight_level_ramp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [blr_pkg::ACT_W-1:0]     in_action,
  input  wire logic [blr_pkg::PCT_W-1:0]     in_percent,
  input  wire logic [blr_pkg::LEVEL_W-1:0]   in_reported_level,

  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic                          out_write_valid,
  output      logic [blr_pkg::LEVEL_W-1:0]   out_write_level,
  output      logic [blr_pkg::PCT_W-1:0]     out_percent_now,
  output      logic                          out_accepted,
  output      logic                          out_change_notice,
  output      logic                          out_last,

  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [blr_pkg::LEVEL_W-1:0]   cfg_max_level
);
  import blr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_TGT_WAIT,
    S_NUDGE,
    S_STEP,
    S_PCT_START,
    S_PCT_WAIT,
    S_EMIT
  } state_t;

  // what the percent conversion feeds into
  typedef enum logic [1:0] {
    M_REPORT,
    M_HOLD,
    M_RAMP
  } mode_t;

  typedef struct packed {
    logic               write_valid;
    logic [LEVEL_W-1:0] write_level;
    logic [PCT_W-1:0]   percent_now;
    logic               accepted;
    logic               change_notice;
    logic               last;
  } result_t;

  state_t             state_r, state_nxt;
  mode_t              mode_r, mode_nxt;
  logic [LEVEL_W-1:0] max_level_r, max_level_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [PCT_W-1:0]   held_pct_r, held_pct_nxt;
  logic [PCT_W-1:0]   pct_r, pct_nxt;
  logic [ACT_W-1:0]   act_r, act_nxt;
  logic [PCT_W-1:0]   in_pct_r, in_pct_nxt;
  logic [LEVEL_W-1:0] rep_r, rep_nxt;
  logic               up_r, up_nxt;
  logic [LEVEL_W-1:0] target_r, target_nxt;
  result_t            pend_r, pend_nxt;
  result_t            out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic [LEVEL_W-1:0] divr;          // d: max below 10, else max - 1
  logic [PCT_W:0]     held_plus;
  logic [PCT_W-1:0]   req_pct;
  logic [PCT_W-1:0]   mul_a;
  logic [DEN_W-1:0]   mul_b;
  logic [14:0]        product;
  logic [LEVEL_W-1:0] nudged;
  logic               slot_free;
  logic               in_take;

  blr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    divr = (max_level_r < SPLIT_LEVEL) ? max_level_r : max_level_r - 1'b1;

    // requested percent for this command
    held_plus = {1'b0, held_pct_r} + {1'b0, STEP_PCT};
    case (action_t'(act_r))
      ACT_SET:  req_pct = in_pct_r;
      ACT_UP:   req_pct = (held_plus > {1'b0, FULL_PCT}) ? FULL_PCT : held_plus[PCT_W-1:0];
      ACT_DOWN: req_pct = (held_pct_r > STEP_PCT) ? held_pct_r - STEP_PCT : '0;
      default:  req_pct = held_pct_r;
    endcase

    // shared multiplier: 2*p*d for percent-to-level, lvl*200 for the reverse
    if (state_r == S_DECIDE) begin
      mul_a = req_pct;
      mul_b = {1'b0, divr, 1'b0};
    end else begin
      mul_a = {1'b0, level_r};
      mul_b = PCT_SCALE;
    end
    product = {8'b0, mul_a} * {7'b0, mul_b};

    // one-step nudge when the target lands on the held level
    nudged = target_r;
    if (target_r == level_r) begin
      if (up_r) begin
        if (target_r < max_level_r) nudged = target_r + 1'b1;
      end else begin
        if (target_r != '0) nudged = target_r - 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    max_level_nxt = max_level_r;
    level_nxt     = level_r;
    held_pct_nxt  = held_pct_r;
    pct_nxt       = pct_r;
    act_nxt       = act_r;
    in_pct_nxt    = in_pct_r;
    rep_nxt       = rep_r;
    up_nxt        = up_r;
    target_nxt    = target_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    div_req.start = 1'b0;
    div_req.num   = product[NUM_W-1:0] + PCT_ROUND;
    div_req.den   = PCT_SCALE;

    if (cfg_valid && cfg_ready) begin
      max_level_nxt = cfg_max_level;
    end

    // drain the result register
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          act_nxt    = in_action;
          in_pct_nxt = in_percent;
          rep_nxt    = in_reported_level;
          state_nxt  = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (action_t'(act_r) == ACT_REPORT) begin
          level_nxt = rep_r;
          mode_nxt  = M_REPORT;
          state_nxt = S_PCT_START;
        end else if (max_level_r <= 6'd1) begin
          // refuse: control unsupported
          pend_nxt  = '{1'b0, level_r, held_pct_r, 1'b0, 1'b0, 1'b1};
          state_nxt = S_EMIT;
        end else if (req_pct == held_pct_r) begin
          pend_nxt  = '{1'b0, level_r, held_pct_r, 1'b1, 1'b0, 1'b1};
          state_nxt = S_EMIT;
        end else begin
          up_nxt = req_pct > held_pct_r;
          if (req_pct > FULL_PCT) begin
            target_nxt = max_level_r;
            state_nxt  = S_NUDGE;
          end else begin
            // level = (2*p*d + 100) / 200
            div_req.start = 1'b1;
            state_nxt     = S_TGT_WAIT;
          end
        end
      end

      S_TGT_WAIT: begin
        if (div_rsp.done) begin
          target_nxt = div_rsp.quot[LEVEL_W-1:0];
          state_nxt  = S_NUDGE;
        end
      end

      S_NUDGE: begin
        target_nxt = nudged;
        if (nudged == level_r) begin
          mode_nxt  = M_HOLD;
          state_nxt = S_PCT_START;
        end else begin
          state_nxt = S_STEP;
        end
      end

      S_STEP: begin
        // advance one level toward the target
        level_nxt = (target_r > level_r) ? level_r + 1'b1 : level_r - 1'b1;
        mode_nxt  = M_RAMP;
        state_nxt = S_PCT_START;
      end

      S_PCT_START: begin
        if (level_r > max_level_r) begin
          pct_nxt   = FULL_PCT;
          state_nxt = S_EMIT;
        end else if (max_level_r == '0) begin
          pct_nxt   = '0;
          state_nxt = S_EMIT;
        end else begin
          // percent = (lvl*200 + d) / (2*d)
          div_req.start = 1'b1;
          div_req.num   = product[NUM_W-1:0] + {{(NUM_W-LEVEL_W){1'b0}}, divr};
          div_req.den   = {1'b0, divr, 1'b0};
          state_nxt     = S_PCT_WAIT;
        end
        if (state_nxt == S_EMIT) begin
          held_pct_nxt = pct_nxt;
          pend_nxt     = '{mode_r == M_RAMP, level_r, pct_nxt, 1'b1,
                           mode_r == M_REPORT,
                           (mode_r != M_RAMP) || (level_r == target_r)};
        end
      end

      S_PCT_WAIT: begin
        if (div_rsp.done) begin
          pct_nxt      = div_rsp.quot;
          held_pct_nxt = div_rsp.quot;
          pend_nxt     = '{mode_r == M_RAMP, level_r, div_rsp.quot, 1'b1,
                           mode_r == M_REPORT,
                           (mode_r != M_RAMP) || (level_r == target_r)};
          state_nxt    = S_EMIT;
        end
      end

      S_EMIT: begin
        // hold until the result register is free
        if (slot_free) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = pend_r.last ? S_IDLE : S_STEP;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= M_HOLD;
      max_level_r <= '0;
      level_r     <= '0;
      held_pct_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      max_level_r <= max_level_nxt;
      level_r     <= level_nxt;
      held_pct_r  <= held_pct_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pct_r    <= pct_nxt;
    act_r    <= act_nxt;
    in_pct_r <= in_pct_nxt;
    rep_r    <= rep_nxt;
    up_r     <= up_nxt;
    target_r <= target_nxt;
    pend_r   <= pend_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_write_valid   = out_r.write_valid;
  assign out_write_level   = out_r.write_level;
  assign out_percent_now   = out_r.percent_now;
  assign out_accepted      = out_r.accepted;
  assign out_change_notice = out_r.change_notice;
  assign out_last          = out_r.last;

`ifndef SYNTHESIS
  a_wait_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PCT_WAIT || state_r == S_TGT_WAIT) |-> (div_rsp.busy || div_rsp.done))
    else $error("waiting on an idle divider");

  a_step_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP) |-> (level_r != target_r))
    else $error("ramp step with level already at target");

  a_nowrite_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.write_valid) |-> out_r.last)
    else $error("result without a write is not the final one");
`endif

endmodule

`default_nettype wire
